FILE: src/obba_pkg.sv
package obba_pkg;

   localparam int GRID_DIM    = 64;
   localparam int COUNT_WIDTH = 16;
   localparam int IDX_W       = $clog2(GRID_DIM);
   localparam int COORD_W     = 6;
   localparam int AREA_W      = 13;
   localparam int SPAN_W      = IDX_W + 1;
   localparam int GRP_SIZE    = 8;
   localparam int GRP_N       = GRID_DIM / GRP_SIZE;
   localparam int GRP_W       = IDX_W - 3;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      CMD_PLACE  = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   // lowest set bit of an 8-bit group
   function automatic logic [2:0] first_set8(input logic [7:0] bits);
      logic [2:0] pos;
      pos = '0;
      for (int j = 7; j >= 0; j--) begin
         if (bits[j]) pos = 3'(j);
      end
      return pos;
   endfunction

   // highest set bit of an 8-bit group
   function automatic logic [2:0] last_set8(input logic [7:0] bits);
      logic [2:0] pos;
      pos = '0;
      for (int j = 0; j < 8; j++) begin
         if (bits[j]) pos = 3'(j);
      end
      return pos;
   endfunction

endpackage

FILE: src/occupancy_bounding_box_area.sv
// flow: the item passes the count memory read-modify-write, the two-stage extent search
//   and the area multiply; a new item is taken only after the result is loaded into
//   the output register, which waits while the output is stalled
// reset: synchronous, active high; clears control, output valid and the per-entry
//   valid bits, so both count memories read as zero right away (no clearing pass)
module occupancy_bounding_box_area
   import obba_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_command,
   input  logic [COORD_W-1:0] req_x_coord,
   input  logic [COORD_W-1:0] req_y_coord,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [AREA_W-1:0]  rsp_area,
   output logic               rsp_is_empty,
   output logic [COORD_W-1:0] rsp_min_column,
   output logic [COORD_W-1:0] rsp_max_column,
   output logic [COORD_W-1:0] rsp_min_row,
   output logic [COORD_W-1:0] rsp_max_row
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_UPD  = 5'b00010,
      S_GRP  = 5'b00100,
      S_SPAN = 5'b01000,
      S_MUL  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [1:0]         cmd_ff;
   logic [COORD_W-1:0] x_ff, y_ff;

   logic [COUNT_WIDTH-1:0] col_mem [GRID_DIM];
   logic [COUNT_WIDTH-1:0] row_mem [GRID_DIM];
   logic [COUNT_WIDTH-1:0] col_rd_ff, row_rd_ff;

   logic [GRID_DIM-1:0] col_valid_ff, row_valid_ff;
   logic [GRID_DIM-1:0] col_occ_ff, row_occ_ff;

   logic                   on_grid;
   logic [COUNT_WIDTH-1:0] col_cnt, row_cnt, col_new, row_new;
   logic                   cnt_we, do_clear;

   logic [GRP_N-1:0] col_any_in, row_any_in, col_any_ff, row_any_ff;
   logic [2:0]       col_first_in [GRP_N];
   logic [2:0]       col_last_in  [GRP_N];
   logic [2:0]       row_first_in [GRP_N];
   logic [2:0]       row_last_in  [GRP_N];
   logic [2:0]       col_first_ff [GRP_N];
   logic [2:0]       col_last_ff  [GRP_N];
   logic [2:0]       row_first_ff [GRP_N];
   logic [2:0]       row_last_ff  [GRP_N];

   logic [IDX_W-1:0] xlo_in, xhi_in, ylo_in, yhi_in;
   logic [IDX_W-1:0] xlo_ff, xhi_ff, ylo_ff, yhi_ff;
   logic             has_x_in, has_y_in, has_x_ff, has_y_ff;

   logic [SPAN_W-1:0]   span_x, span_y;
   logic [2*SPAN_W-1:0] product;
   logic                out_load;

   logic               rsp_valid_ff;
   logic [AREA_W-1:0]  area_ff;
   logic               empty_ff;
   logic [COORD_W-1:0] min_col_ff, max_col_ff, min_row_ff, max_row_ff;

   assign req_stall = (state_ff != S_IDLE);

   // count update
   always_comb begin
      on_grid  = (32'(x_ff) < 32'(GRID_DIM)) && (32'(y_ff) < 32'(GRID_DIM));
      col_cnt  = col_valid_ff[x_ff[IDX_W-1:0]] ? col_rd_ff : '0;
      row_cnt  = row_valid_ff[y_ff[IDX_W-1:0]] ? row_rd_ff : '0;
      col_new  = col_cnt;
      row_new  = row_cnt;
      cnt_we   = 1'b0;
      do_clear = 1'b0;
      if (state_ff == S_UPD) begin
         case (cmd_ff)
            CMD_PLACE: begin
               if (on_grid) begin
                  cnt_we = 1'b1;
                  if (col_cnt != COUNT_MAX) col_new = col_cnt + 1'b1;
                  if (row_cnt != COUNT_MAX) row_new = row_cnt + 1'b1;
               end
            end
            CMD_REMOVE: begin
               if (on_grid && (col_cnt != '0) && (row_cnt != '0)) begin
                  cnt_we  = 1'b1;
                  col_new = col_cnt - 1'b1;
                  row_new = row_cnt - 1'b1;
               end
            end
            CMD_CLEAR: do_clear = 1'b1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         col_mem[x_ff[IDX_W-1:0]] <= col_new;
         row_mem[y_ff[IDX_W-1:0]] <= row_new;
      end
      col_rd_ff <= col_mem[req_x_coord[IDX_W-1:0]];
      row_rd_ff <= row_mem[req_y_coord[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_valid_ff <= '0;
         row_valid_ff <= '0;
         col_occ_ff   <= '0;
         row_occ_ff   <= '0;
      end else if (do_clear) begin
         col_valid_ff <= '0;
         row_valid_ff <= '0;
         col_occ_ff   <= '0;
         row_occ_ff   <= '0;
      end else if (cnt_we) begin
         col_valid_ff[x_ff[IDX_W-1:0]] <= 1'b1;
         row_valid_ff[y_ff[IDX_W-1:0]] <= 1'b1;
         col_occ_ff[x_ff[IDX_W-1:0]]   <= (col_new != '0);
         row_occ_ff[y_ff[IDX_W-1:0]]   <= (row_new != '0);
      end
   end

   // extent search, first level: per group of eight
   always_comb begin
      for (int g = 0; g < GRP_N; g++) begin
         col_any_in[g]   = |col_occ_ff[g*GRP_SIZE +: GRP_SIZE];
         row_any_in[g]   = |row_occ_ff[g*GRP_SIZE +: GRP_SIZE];
         col_first_in[g] = first_set8(col_occ_ff[g*GRP_SIZE +: GRP_SIZE]);
         col_last_in[g]  = last_set8(col_occ_ff[g*GRP_SIZE +: GRP_SIZE]);
         row_first_in[g] = first_set8(row_occ_ff[g*GRP_SIZE +: GRP_SIZE]);
         row_last_in[g]  = last_set8(row_occ_ff[g*GRP_SIZE +: GRP_SIZE]);
      end
   end

   // second level: across groups
   always_comb begin
      xlo_in = '0;
      xhi_in = '0;
      ylo_in = '0;
      yhi_in = '0;
      for (int g = GRP_N - 1; g >= 0; g--) begin
         if (col_any_ff[g]) xlo_in = {GRP_W'(g), col_first_ff[g]};
         if (row_any_ff[g]) ylo_in = {GRP_W'(g), row_first_ff[g]};
      end
      for (int g = 0; g < GRP_N; g++) begin
         if (col_any_ff[g]) xhi_in = {GRP_W'(g), col_last_ff[g]};
         if (row_any_ff[g]) yhi_in = {GRP_W'(g), row_last_ff[g]};
      end
      has_x_in = |col_any_ff;
      has_y_in = |row_any_ff;
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_GRP) begin
         col_any_ff   <= col_any_in;
         row_any_ff   <= row_any_in;
         col_first_ff <= col_first_in;
         col_last_ff  <= col_last_in;
         row_first_ff <= row_first_in;
         row_last_ff  <= row_last_in;
      end
      if (state_ff == S_SPAN) begin
         xlo_ff   <= xlo_in;
         xhi_ff   <= xhi_in;
         ylo_ff   <= ylo_in;
         yhi_ff   <= yhi_in;
         has_x_ff <= has_x_in;
         has_y_ff <= has_y_in;
      end
   end

   // area
   assign span_x  = {1'b0, xhi_ff} - {1'b0, xlo_ff} + SPAN_W'(1);
   assign span_y  = {1'b0, yhi_ff} - {1'b0, ylo_ff} + SPAN_W'(1);
   assign product = span_x * span_y;

   assign out_load = (state_ff == S_MUL) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_valid) state_in = S_UPD;
         S_UPD:  state_in = S_GRP;
         S_GRP:  state_in = S_SPAN;
         S_SPAN: state_in = S_MUL;
         S_MUL:  if (out_load) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         cmd_ff <= req_command;
         x_ff   <= req_x_coord;
         y_ff   <= req_y_coord;
      end
      if (out_load) begin
         if (has_x_ff && has_y_ff) begin
            area_ff    <= product[AREA_W-1:0];
            empty_ff   <= 1'b0;
            min_col_ff <= COORD_W'(xlo_ff);
            max_col_ff <= COORD_W'(xhi_ff);
            min_row_ff <= COORD_W'(ylo_ff);
            max_row_ff <= COORD_W'(yhi_ff);
         end else begin
            area_ff    <= '0;
            empty_ff   <= 1'b1;
            min_col_ff <= '0;
            max_col_ff <= '0;
            min_row_ff <= '0;
            max_row_ff <= '0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_area       = area_ff;
   assign rsp_is_empty   = empty_ff;
   assign rsp_min_column = min_col_ff;
   assign rsp_max_column = max_col_ff;
   assign rsp_min_row    = min_row_ff;
   assign rsp_max_row    = max_row_ff;

endmodule

FILE: tb/bounding_box_checker.sv
module bounding_box_checker
   import obba_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [1:0]         req_command,
   input  logic [COORD_W-1:0] req_x_coord,
   input  logic [COORD_W-1:0] req_y_coord,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [AREA_W-1:0]  rsp_area,
   input  logic               rsp_is_empty,
   input  logic [COORD_W-1:0] rsp_min_column,
   input  logic [COORD_W-1:0] rsp_max_column,
   input  logic [COORD_W-1:0] rsp_min_row,
   input  logic [COORD_W-1:0] rsp_max_row,
   output int                 mismatches,
   output int                 boxes_due
);

   typedef struct packed {
      logic [AREA_W-1:0]  area;
      logic               is_empty;
      logic [COORD_W-1:0] min_column;
      logic [COORD_W-1:0] max_column;
      logic [COORD_W-1:0] min_row;
      logic [COORD_W-1:0] max_row;
   } box_type;

   logic [COUNT_WIDTH-1:0] column_uses [GRID_DIM];
   logic [COUNT_WIDTH-1:0] row_uses [GRID_DIM];
   box_type expected_boxes [$];
   int fails = 0;

   initial begin
      mismatches = 0;
      boxes_due  = 0;
   end

   // updates the use counts for one item and returns the box it leaves
   function automatic box_type apply_command(input cmd_type cmd,
                                             input logic [COORD_W-1:0] x,
                                             input logic [COORD_W-1:0] y);
      box_type box;
      int   col_lo;
      int   col_hi;
      int   row_lo;
      int   row_hi;
      bit   on_grid;
      on_grid = (int'(x) < GRID_DIM) && (int'(y) < GRID_DIM);
      case (cmd)
         CMD_PLACE: begin
            if (on_grid) begin
               // each count saturates on its own
               if (column_uses[x] != COUNT_MAX) column_uses[x] = column_uses[x] + 1'b1;
               if (row_uses[y] != COUNT_MAX) row_uses[y] = row_uses[y] + 1'b1;
            end
         end
         CMD_REMOVE: begin
            if (on_grid && column_uses[x] != '0 && row_uses[y] != '0) begin
               column_uses[x] = column_uses[x] - 1'b1;
               row_uses[y]    = row_uses[y] - 1'b1;
            end
         end
         CMD_CLEAR: begin
            for (int i = 0; i < GRID_DIM; i++) begin
               column_uses[i] = '0;
               row_uses[i]    = '0;
            end
         end
         default: ;
      endcase
      col_lo = -1;
      col_hi = -1;
      row_lo = -1;
      row_hi = -1;
      for (int i = 0; i < GRID_DIM; i++) begin
         if (column_uses[i] != '0) begin
            if (col_lo < 0) col_lo = i;
            col_hi = i;
         end
         if (row_uses[i] != '0) begin
            if (row_lo < 0) row_lo = i;
            row_hi = i;
         end
      end
      box = '0;
      // columns and rows can disagree after saturation: either side empty means empty
      if (col_lo >= 0 && row_lo >= 0) begin
         box.area       = AREA_W'((col_hi - col_lo + 1) * (row_hi - row_lo + 1));
         box.min_column = COORD_W'(col_lo);
         box.max_column = COORD_W'(col_hi);
         box.min_row    = COORD_W'(row_lo);
         box.max_row    = COORD_W'(row_hi);
      end else begin
         box.is_empty = 1'b1;
      end
      return box;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s expected %0d got %0d", name, want, got);
         fails++;
      end
   endtask

   always @(posedge clock) begin : watch
      box_type want;
      if (reset) begin
         for (int i = 0; i < GRID_DIM; i++) begin
            column_uses[i] = '0;
            row_uses[i]    = '0;
         end
         expected_boxes.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_boxes.size() == 0) begin
               $error("result item with no item outstanding");
               fails++;
            end else begin
               want = expected_boxes.pop_front();
               check_field("area", 16'(want.area), 16'(rsp_area));
               check_field("is_empty", 16'(want.is_empty), 16'(rsp_is_empty));
               check_field("min_column", 16'(want.min_column), 16'(rsp_min_column));
               check_field("max_column", 16'(want.max_column), 16'(rsp_max_column));
               check_field("min_row", 16'(want.min_row), 16'(rsp_min_row));
               check_field("max_row", 16'(want.max_row), 16'(rsp_max_row));
            end
         end
         if (req_valid && !req_stall)
            expected_boxes.insert(expected_boxes.size(),
                                  apply_command(cmd_type'(req_command),
                                                req_x_coord, req_y_coord));
      end
      mismatches <= fails;
      boxes_due  <= expected_boxes.size();
   end

endmodule

FILE: tb/tb_occupancy_bounding_box_area.sv
module tb_occupancy_bounding_box_area;
   import obba_pkg::*;

   localparam int RANDOM_ITEMS  = 1550;
   localparam int HOLD_CYCLES   = 300;
   localparam int IDLE_LIMIT    = 3000;
   localparam int SETTLE_CYCLES = 20;
   localparam int COLUMN_ITEMS  = 40;

   typedef struct {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } spot_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_command = CMD_NONE;
   logic [COORD_W-1:0] req_x_coord = '0;
   logic [COORD_W-1:0] req_y_coord = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [AREA_W-1:0]  rsp_area;
   logic               rsp_is_empty;
   logic [COORD_W-1:0] rsp_min_column;
   logic [COORD_W-1:0] rsp_max_column;
   logic [COORD_W-1:0] rsp_min_row;
   logic [COORD_W-1:0] rsp_max_row;

   int       mismatches;
   int       boxes_due;
   int       idle_cycles = 0;
   bit       gaps_on = 1'b0;
   bit       stalls_on = 1'b0;
   bit       hold_request = 1'b0;
   spot_type placed_spots [$];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   occupancy_bounding_box_area dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_x_coord    (req_x_coord),
      .req_y_coord    (req_y_coord),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_area       (rsp_area),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_min_column (rsp_min_column),
      .rsp_max_column (rsp_max_column),
      .rsp_min_row    (rsp_min_row),
      .rsp_max_row    (rsp_max_row)
   );

   bounding_box_checker scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_x_coord    (req_x_coord),
      .req_y_coord    (req_y_coord),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_area       (rsp_area),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_min_column (rsp_min_column),
      .rsp_max_column (rsp_max_column),
      .rsp_min_row    (rsp_min_row),
      .rsp_max_row    (rsp_max_row),
      .mismatches     (mismatches),
      .boxes_due      (boxes_due)
   );

   // offer one item and return at the edge that takes it; valid stays high
   task automatic send_item(input cmd_type cmd, input logic [COORD_W-1:0] x,
                            input logic [COORD_W-1:0] y);
      req_command <= cmd;
      req_x_coord <= x;
      req_y_coord <= y;
      req_valid   <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic sender_gap();
      int r;
      int n;
      r = $urandom_range(0, 99);
      n = 0;
      if (gaps_on) begin
         if (r >= 96) n = $urandom_range(20, 60);
         else if (r >= 65) n = $urandom_range(1, 6);
      end
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   function automatic logic [COORD_W-1:0] pick_coord();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      if (r < 5) return COORD_W'($urandom_range(20, 40));
      return COORD_W'($urandom_range(0, 63));
   endfunction

   task automatic send_random_item();
      int       r;
      int       k;
      spot_type s;
      r   = $urandom_range(0, 99);
      s.x = pick_coord();
      s.y = pick_coord();
      if (r < 50) begin
         placed_spots.insert(placed_spots.size(), s);
         send_item(CMD_PLACE, s.x, s.y);
      end else if (r < 82 && placed_spots.size() > 0) begin
         // mostly take back something that was placed
         k = $urandom_range(0, placed_spots.size() - 1);
         s = placed_spots[k];
         placed_spots.delete(k);
         send_item(CMD_REMOVE, s.x, s.y);
      end else if (r < 90) begin
         send_item(CMD_REMOVE, s.x, s.y);
      end else if (r < 95) begin
         placed_spots.delete();
         send_item(CMD_CLEAR, s.x, s.y);
      end else begin
         send_item(CMD_NONE, s.x, s.y);
      end
   endtask

   // receiver side: random stall stretches, or one long hold-off on request
   initial begin : receiver
      int left;
      int r;
      bit level;
      left  = 0;
      level = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            left = 0;
         end else if (!stalls_on) begin
            rsp_stall <= 1'b0;
            left = 0;
         end else begin
            if (left == 0) begin
               r = $urandom_range(0, 99);
               if (r < 30) begin
                  level = 1'b1;
                  left  = $urandom_range(1, 5);
               end else if (r < 34) begin
                  level = 1'b1;
                  left  = $urandom_range(20, 60);
               end else begin
                  level = 1'b0;
                  left  = $urandom_range(1, 8);
               end
            end
            rsp_stall <= level;
            left--;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $error("no item moved for %0d cycles", IDLE_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // corners, every command, removes that must be refused
      send_item(CMD_PLACE, 6'd0, 6'd0);
      send_item(CMD_PLACE, 6'd63, 6'd63);
      send_item(CMD_PLACE, 6'd63, 6'd0);
      send_item(CMD_PLACE, 6'd0, 6'd63);
      send_item(CMD_REMOVE, 6'd63, 6'd63);
      send_item(CMD_REMOVE, 6'd10, 6'd10);
      send_item(CMD_REMOVE, 6'd63, 6'd5);
      send_item(CMD_NONE, 6'd63, 6'd63);
      send_item(CMD_REMOVE, 6'd0, 6'd0);
      send_item(CMD_REMOVE, 6'd0, 6'd63);
      send_item(CMD_REMOVE, 6'd63, 6'd0);
      send_item(CMD_REMOVE, 6'd0, 6'd0);
      send_item(CMD_PLACE, 6'b101010, 6'b010101);
      send_item(CMD_PLACE, 6'b010101, 6'b101010);
      send_item(CMD_PLACE, 6'd31, 6'd32);
      send_item(CMD_CLEAR, 6'd63, 6'd63);
      send_item(CMD_REMOVE, 6'd0, 6'd0);
      send_item(CMD_NONE, 6'd0, 6'd0);

      // stack column 0 over many rows, then drain it again
      for (int i = 0; i < COLUMN_ITEMS; i++) send_item(CMD_PLACE, 6'd0, COORD_W'(i));
      for (int i = 0; i < COLUMN_ITEMS; i++) send_item(CMD_REMOVE, 6'd0, COORD_W'(i));
      send_item(CMD_REMOVE, 6'd0, 6'd5);
      send_item(CMD_PLACE, 6'd7, 6'd9);
      send_item(CMD_CLEAR, 6'd0, 6'd0);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         stalls_on = (i >= 150);
         gaps_on   = (i >= 150) && !(i >= 600 && i < 660);
         if (i == 600) hold_request = 1'b1;
         if (i == 1000) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (boxes_due != 0);
         end
         send_random_item();
         sender_gap();
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (boxes_due != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && boxes_due == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: sim.f
src/obba_pkg.sv
src/occupancy_bounding_box_area.sv
tb/bounding_box_checker.sv
tb/tb_occupancy_bounding_box_area.sv
